// ===== hdl/p2d_pkg.sv =====
package p2d_pkg;

  // table geometry and field widths
  localparam int ROWS    = 64;
  localparam int COLS    = 64;
  localparam int RB      = 6;
  localparam int CB      = 6;
  localparam int IDX_W   = (RB > CB) ? RB : CB;
  localparam int CELL_AW = RB + CB;
  localparam int WB      = 16;
  localparam int FB      = 24;
  localparam int PF_W    = 22;
  localparam int MP_W    = 28;
  localparam int TGT_W   = MP_W + FB;
  localparam int PDF_W   = 32;

  // shared divider geometry
  localparam int DVD_W   = 44;
  localparam int DVS_W   = 28;
  localparam int Q_W     = 32;
  localparam int DEN_SH  = RB + CB + 16;
  localparam int SAT_SH  = Q_W - DEN_SH;
  localparam int FRAC_U  = FB - CB;
  localparam int FRAC_V  = FB - RB;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // query cells travel in row/col
  typedef struct packed {
    req_e          kind;
    logic [RB-1:0] row;
    logic [CB-1:0] col;
    logic [WB-1:0] weight;
    logic [FB-1:0] rand_row;
    logic [FB-1:0] rand_col;
  } cmd_t;

  typedef struct packed {
    logic [FB-1:0]    u_coord;
    logic [FB-1:0]    v_coord;
    logic [PDF_W-1:0] pdf_value;
    logic [RB-1:0]    row_index;
    logic [CB-1:0]    col_index;
    logic             status;
  } res_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_LD_RD, ST_LD_WR, ST_PF_RD, ST_PF_WR, ST_RT_RD, ST_RT_WR, ST_MP_RD, ST_MP_WR,
    ST_MUL, ST_S_RD, ST_S_CMP, ST_R_RD, ST_R_GOT, ST_V_WAIT,
    ST_C_RD, ST_C_GOT, ST_U_WAIT, ST_Q_RD, ST_Q_GOT, ST_P_WAIT, ST_RESULT
  } back_state_e;

endpackage

// ===== hdl/p2d_ram.sv =====
module p2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/p2d_fifo.sv =====
module p2d_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wp_q, rp_q;
  logic [PW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + 1'b1;
      if (do_pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/p2d_front.sv =====
module p2d_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic                          clearing_i,
  input  logic [1:0]                    req_type_i,
  input  logic [p2d_pkg::RB-1:0]        row_i,
  input  logic [p2d_pkg::CB-1:0]        col_i,
  input  logic [p2d_pkg::WB-1:0]        weight_i,
  input  logic [p2d_pkg::FB-1:0]        rand_row_i,
  input  logic [p2d_pkg::FB-1:0]        rand_col_i,
  input  logic [p2d_pkg::FB-1:0]        query_u_i,
  input  logic [p2d_pkg::FB-1:0]        query_v_i,
  input  logic                          cmd_pop_i,
  output p2d_pkg::cmd_t                 cmd_o,
  output logic                          cmd_empty_o
);

  p2d_pkg::cmd_t                      cmd_in;
  logic                               q_full;
  logic [$bits(p2d_pkg::cmd_t)-1:0]   q_rdata;

  // query point maps to its cell: top bits of each fraction
  always_comb begin
    cmd_in          = '0;
    cmd_in.kind     = p2d_pkg::req_e'(req_type_i);
    cmd_in.weight   = weight_i;
    cmd_in.rand_row = rand_row_i;
    cmd_in.rand_col = rand_col_i;
    if (cmd_in.kind == p2d_pkg::REQ_QUERY) begin
      cmd_in.row = query_v_i[p2d_pkg::FB-1 -: p2d_pkg::RB];
      cmd_in.col = query_u_i[p2d_pkg::FB-1 -: p2d_pkg::CB];
    end else begin
      cmd_in.row = row_i;
      cmd_in.col = col_i;
    end
  end

  assign full_o = q_full || clearing_i;

  p2d_fifo #(
    .WIDTH($bits(p2d_pkg::cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i && !clearing_i),
    .wdata_i(cmd_in),
    .full_o (q_full),
    .pop_i  (cmd_pop_i),
    .rdata_o(q_rdata),
    .empty_o(cmd_empty_o)
  );

  assign cmd_o = p2d_pkg::cmd_t'(q_rdata);

endmodule

// ===== hdl/p2d_div.sv =====
module p2d_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [p2d_pkg::DVD_W-1:0] dividend_i,
  input  logic [p2d_pkg::DVS_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [p2d_pkg::Q_W-1:0]   quo_o
);

  localparam int QW = p2d_pkg::Q_W;
  localparam int DW = p2d_pkg::DVS_W;
  localparam int CW = $clog2(QW + 1);

  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW-1:0] rem_q, dvs_q;
  logic [QW-1:0] acc_q;
  logic [DW:0]   trial;
  logic          ge;

  // restoring divide, one quotient bit a cycle
  assign trial = {rem_q, acc_q[QW-1]};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(QW);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != CW'(1));
      done_q <= (cnt_q == CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DW'(dividend_i[p2d_pkg::DVD_W-1:QW]);
      acc_q <= dividend_i[QW-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
      acc_q <= {acc_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = acc_q;

endmodule

// ===== hdl/p2d_back.sv =====
module p2d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  p2d_pkg::cmd_t  cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output logic           clearing_o,
  output logic           res_push_o,
  output p2d_pkg::res_t  res_o,
  input  logic           res_full_i
);

  localparam int RB = p2d_pkg::RB;
  localparam int CB = p2d_pkg::CB;
  localparam int AW = p2d_pkg::CELL_AW;
  localparam int IW = p2d_pkg::IDX_W;
  localparam int WB = p2d_pkg::WB;
  localparam int FB = p2d_pkg::FB;
  localparam int PW = p2d_pkg::PF_W;
  localparam int MW = p2d_pkg::MP_W;
  localparam int TW = p2d_pkg::TGT_W;
  localparam int DV = p2d_pkg::DVD_W;
  localparam int DS = p2d_pkg::DVS_W;
  localparam int FU = p2d_pkg::FRAC_U;
  localparam int FV = p2d_pkg::FRAC_V;

  p2d_pkg::back_state_e state_q, state_d;
  p2d_pkg::cmd_t        cmd_q, cmd_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [IW-1:0]        lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, mid;
  logic                 colph_q, colph_d;
  logic [RB-1:0]        r_q, r_d;
  logic [MW-1:0]        delta_q, delta_d, grand_q, grand_d;
  logic [TW-1:0]        tgt_q, tgt_d, off;
  logic [PW-1:0]        rt_q, rt_d;
  logic [WB-1:0]        w_q, w_d;
  p2d_pkg::res_t        res_q, res_d;
  logic [MW-1:0]        pref;

  logic          w_we, pf_we, rt_we, mp_we;
  logic [AW-1:0] w_waddr, w_raddr, pf_waddr, pf_raddr;
  logic [RB-1:0] rt_waddr, rt_raddr, mp_waddr, mp_raddr;
  logic [WB-1:0] w_wdata, w_rd;
  logic [PW-1:0] pf_wdata, pf_rd, rt_wdata, rt_rd;
  logic [MW-1:0] mp_wdata, mp_rd;

  logic                    div_start, div_done;
  logic [DV-1:0]           div_dvd;
  logic [DS-1:0]           div_dvs;
  logic [p2d_pkg::Q_W-1:0] div_quo;
  logic                    sat;

  assign mid  = IW'(({1'b0, lo_q} + {1'b0, hi_q} + 1'b1) >> 1);
  assign pref = colph_q ? MW'(pf_rd) : mp_rd;
  assign sat  = (DV'(w_q) >= (DV'(grand_q) << p2d_pkg::SAT_SH));

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    clr_d   = clr_q;
    idx_d   = idx_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    colph_d = colph_q;
    r_d     = r_q;
    delta_d = delta_q;
    grand_d = grand_q;
    tgt_d   = tgt_q;
    rt_d    = rt_q;
    w_d     = w_q;
    res_d   = res_q;
    off     = '0;
    w_we = 1'b0;  w_waddr  = {cmd_q.row, cmd_q.col}; w_wdata  = cmd_q.weight;
    pf_we = 1'b0; pf_waddr = {cmd_q.row, CB'(idx_q)}; pf_wdata = pf_rd + delta_q[PW-1:0];
    rt_we = 1'b0; rt_waddr = cmd_q.row;               rt_wdata = rt_rd + delta_q[PW-1:0];
    mp_we = 1'b0; mp_waddr = RB'(idx_q);              mp_wdata = mp_rd + delta_q;
    w_raddr  = {cmd_q.row, cmd_q.col};
    pf_raddr = {cmd_q.row, CB'(idx_q)};
    rt_raddr = cmd_q.row;
    mp_raddr = RB'(idx_q);
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;

    unique case (state_q)
      p2d_pkg::ST_CLEAR: begin
        w_we = 1'b1;  w_waddr  = clr_q; w_wdata  = '0;
        pf_we = 1'b1; pf_waddr = clr_q; pf_wdata = '0;
        rt_we = (clr_q[AW-1:RB] == '0); rt_waddr = clr_q[RB-1:0]; rt_wdata = '0;
        mp_we = (clr_q[AW-1:RB] == '0); mp_waddr = clr_q[RB-1:0]; mp_wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) state_d = p2d_pkg::ST_IDLE;
      end
      p2d_pkg::ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          res_d     = '0;
          unique case (cmd_i.kind)
            p2d_pkg::REQ_LOAD: state_d = p2d_pkg::ST_LD_RD;
            p2d_pkg::REQ_SAMPLE: begin
              if (grand_q == '0) begin
                res_d.status = 1'b1;
                state_d      = p2d_pkg::ST_RESULT;
              end else begin
                state_d = p2d_pkg::ST_MUL;
              end
            end
            p2d_pkg::REQ_QUERY: begin
              res_d.row_index = cmd_i.row;
              res_d.col_index = cmd_i.col;
              if (grand_q == '0) begin
                res_d.status = 1'b1;
                state_d      = p2d_pkg::ST_RESULT;
              end else begin
                state_d = p2d_pkg::ST_Q_RD;
              end
            end
            default: state_d = p2d_pkg::ST_RESULT;
          endcase
        end
      end
      p2d_pkg::ST_LD_RD: state_d = p2d_pkg::ST_LD_WR;
      p2d_pkg::ST_LD_WR: begin
        w_we    = 1'b1;
        delta_d = MW'(cmd_q.weight) - MW'(w_rd);
        if (cmd_q.col == CB'(p2d_pkg::COLS - 1)) begin
          state_d = p2d_pkg::ST_RT_RD;
        end else begin
          idx_d   = IW'(cmd_q.col) + 1'b1;
          state_d = p2d_pkg::ST_PF_RD;
        end
      end
      p2d_pkg::ST_PF_RD: state_d = p2d_pkg::ST_PF_WR;
      p2d_pkg::ST_PF_WR: begin
        pf_we = 1'b1;
        if (idx_q == IW'(p2d_pkg::COLS - 1)) begin
          state_d = p2d_pkg::ST_RT_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = p2d_pkg::ST_PF_RD;
        end
      end
      p2d_pkg::ST_RT_RD: state_d = p2d_pkg::ST_RT_WR;
      p2d_pkg::ST_RT_WR: begin
        rt_we   = 1'b1;
        grand_d = grand_q + delta_q;
        if (cmd_q.row == RB'(p2d_pkg::ROWS - 1)) begin
          state_d = p2d_pkg::ST_RESULT;
        end else begin
          idx_d   = IW'(cmd_q.row) + 1'b1;
          state_d = p2d_pkg::ST_MP_RD;
        end
      end
      p2d_pkg::ST_MP_RD: state_d = p2d_pkg::ST_MP_WR;
      p2d_pkg::ST_MP_WR: begin
        mp_we = 1'b1;
        if (idx_q == IW'(p2d_pkg::ROWS - 1)) begin
          state_d = p2d_pkg::ST_RESULT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = p2d_pkg::ST_MP_RD;
        end
      end
      p2d_pkg::ST_MUL: begin
        tgt_d   = TW'(cmd_q.rand_row) * TW'(grand_q);
        lo_d    = '0;
        hi_d    = IW'(p2d_pkg::ROWS - 1);
        colph_d = 1'b0;
        state_d = p2d_pkg::ST_S_RD;
      end
      p2d_pkg::ST_S_RD: begin
        if (lo_q == hi_q) begin
          state_d = colph_q ? p2d_pkg::ST_C_RD : p2d_pkg::ST_R_RD;
        end else begin
          mid_d    = mid;
          mp_raddr = RB'(mid);
          pf_raddr = {r_q, CB'(mid)};
          state_d  = p2d_pkg::ST_S_CMP;
        end
      end
      p2d_pkg::ST_S_CMP: begin
        if ({pref, FB'(0)} <= tgt_q) lo_d = mid_q;
        else                         hi_d = mid_q - 1'b1;
        state_d = p2d_pkg::ST_S_RD;
      end
      p2d_pkg::ST_R_RD: begin
        rt_raddr = RB'(lo_q);
        mp_raddr = RB'(lo_q);
        r_d      = RB'(lo_q);
        state_d  = p2d_pkg::ST_R_GOT;
      end
      p2d_pkg::ST_R_GOT: begin
        rt_d      = rt_rd;
        off       = tgt_q - {mp_rd, FB'(0)};
        div_start = 1'b1;
        div_dvd   = DV'(off >> RB);
        div_dvs   = DS'(rt_rd);
        tgt_d     = TW'(cmd_q.rand_col) * TW'(rt_rd);
        state_d   = p2d_pkg::ST_V_WAIT;
      end
      p2d_pkg::ST_V_WAIT: begin
        if (div_done) begin
          res_d.v_coord = {r_q, (rt_q == '0) ? FV'(0) : div_quo[FV-1:0]};
          lo_d    = '0;
          hi_d    = IW'(p2d_pkg::COLS - 1);
          colph_d = 1'b1;
          state_d = p2d_pkg::ST_S_RD;
        end
      end
      p2d_pkg::ST_C_RD: begin
        pf_raddr = {r_q, CB'(lo_q)};
        w_raddr  = {r_q, CB'(lo_q)};
        state_d  = p2d_pkg::ST_C_GOT;
      end
      p2d_pkg::ST_C_GOT: begin
        w_d       = w_rd;
        off       = tgt_q - {MW'(pf_rd), FB'(0)};
        div_start = 1'b1;
        div_dvd   = DV'(off >> CB);
        div_dvs   = DS'(w_rd);
        state_d   = p2d_pkg::ST_U_WAIT;
      end
      p2d_pkg::ST_U_WAIT: begin
        if (div_done) begin
          res_d.u_coord   = {CB'(lo_q), (w_q == '0) ? FU'(0) : div_quo[FU-1:0]};
          res_d.row_index = r_q;
          res_d.col_index = CB'(lo_q);
          div_start = 1'b1;
          div_dvd   = DV'(w_q) << p2d_pkg::DEN_SH;
          div_dvs   = DS'(grand_q);
          state_d   = p2d_pkg::ST_P_WAIT;
        end
      end
      p2d_pkg::ST_Q_RD: state_d = p2d_pkg::ST_Q_GOT;
      p2d_pkg::ST_Q_GOT: begin
        w_d       = w_rd;
        div_start = 1'b1;
        div_dvd   = DV'(w_rd) << p2d_pkg::DEN_SH;
        div_dvs   = DS'(grand_q);
        state_d   = p2d_pkg::ST_P_WAIT;
      end
      p2d_pkg::ST_P_WAIT: begin
        if (div_done) begin
          res_d.pdf_value = sat ? '1 : div_quo;
          state_d         = p2d_pkg::ST_RESULT;
        end
      end
      p2d_pkg::ST_RESULT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = p2d_pkg::ST_IDLE;
        end
      end
      default: state_d = p2d_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= p2d_pkg::ST_CLEAR;
      clr_q   <= '0;
      grand_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      grand_q <= grand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    idx_q   <= idx_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    colph_q <= colph_d;
    r_q     <= r_d;
    delta_q <= delta_d;
    tgt_q   <= tgt_d;
    rt_q    <= rt_d;
    w_q     <= w_d;
    res_q   <= res_d;
  end

  assign clearing_o = (state_q == p2d_pkg::ST_CLEAR);
  assign res_o      = res_q;

  p2d_ram #(.WIDTH(WB), .DEPTH(p2d_pkg::ROWS * p2d_pkg::COLS)) u_w_ram (
    .clk_i(clk_i), .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .raddr_i(w_raddr), .rdata_o(w_rd)
  );

  p2d_ram #(.WIDTH(PW), .DEPTH(p2d_pkg::ROWS * p2d_pkg::COLS)) u_pf_ram (
    .clk_i(clk_i), .we_i(pf_we), .waddr_i(pf_waddr), .wdata_i(pf_wdata),
    .raddr_i(pf_raddr), .rdata_o(pf_rd)
  );

  p2d_ram #(.WIDTH(PW), .DEPTH(p2d_pkg::ROWS)) u_rt_ram (
    .clk_i(clk_i), .we_i(rt_we), .waddr_i(rt_waddr), .wdata_i(rt_wdata),
    .raddr_i(rt_raddr), .rdata_o(rt_rd)
  );

  p2d_ram #(.WIDTH(MW), .DEPTH(p2d_pkg::ROWS)) u_mp_ram (
    .clk_i(clk_i), .we_i(mp_we), .waddr_i(mp_waddr), .wdata_i(mp_wdata),
    .raddr_i(mp_raddr), .rdata_o(mp_rd)
  );

  p2d_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quo_o     (div_quo)
  );

endmodule

// ===== hdl/piecewise_2d_inverse_cdf_sampler.sv =====
// 2d piecewise-constant inverse-cdf sampler over a 64 x 64 weight table
// input side is a queue: drive the request fields with push_i while full_o is low;
// req_type picks load (write one weight), sample (two uniform 0.24 fractions
// to a (u,v) point plus density) or query (density of the cell holding a point)
// result side is a queue: a result beat sits on the ports while empty_o is low
// and leaves on pop_i; every request gives exactly one result beat
// a two-entry command queue decouples the decoder from the execution unit, and
// a two-entry result queue lets the unit keep going while the receiver stalls;
// when that queue fills, the unit holds its finished result and stops pulling
// commands, so full_o rises once the command queue backs up
// the time a beat takes, from input accept to result on the ports, is set by the single
// read port per table memory and the shared one-bit-per-cycle divider:
//   load   : read-modify-write of the weight, later column prefixes, row total, later row prefixes
//   sample : two 6-step searches, three divisions
//   query  : one table read, one division
//   zero total or unknown type : no search and no division, straight to the result
// one request is worked on at a time: no new command is taken until the last result is pushed
// after reset the tables are swept to zero, one cell per cycle, and full_o stays
// high until the sweep is done
module piecewise_2d_inverse_cdf_sampler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [1:0]                   req_type_i,
  input  logic [p2d_pkg::RB-1:0]       row_i,
  input  logic [p2d_pkg::CB-1:0]       col_i,
  input  logic [p2d_pkg::WB-1:0]       weight_i,
  input  logic [p2d_pkg::FB-1:0]       rand_row_i,
  input  logic [p2d_pkg::FB-1:0]       rand_col_i,
  input  logic [p2d_pkg::FB-1:0]       query_u_i,
  input  logic [p2d_pkg::FB-1:0]       query_v_i,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [p2d_pkg::FB-1:0]       u_coord_o,
  output logic [p2d_pkg::FB-1:0]       v_coord_o,
  output logic [p2d_pkg::PDF_W-1:0]    pdf_value_o,
  output logic [p2d_pkg::RB-1:0]       row_index_o,
  output logic [p2d_pkg::CB-1:0]       col_index_o,
  output logic                         status_o
);

  // front to back command channel
  p2d_pkg::cmd_t cmd;
  logic          cmd_empty;
  logic          cmd_pop;
  logic          clearing;

  // back to result queue
  p2d_pkg::res_t res_in;
  p2d_pkg::res_t res_out;
  logic          res_push;
  logic          res_full;
  logic [$bits(p2d_pkg::res_t)-1:0] res_rdata;

  // decode and queue incoming beats
  p2d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .clearing_i (clearing),
    .req_type_i (req_type_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .weight_i   (weight_i),
    .rand_row_i (rand_row_i),
    .rand_col_i (rand_col_i),
    .query_u_i  (query_u_i),
    .query_v_i  (query_v_i),
    .cmd_pop_i  (cmd_pop),
    .cmd_o      (cmd),
    .cmd_empty_o(cmd_empty)
  );

  // table memories, searches and divider
  p2d_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .clearing_o (clearing),
    .res_push_o (res_push),
    .res_o      (res_in),
    .res_full_i (res_full)
  );

  // finished results wait here for the receiver
  p2d_fifo #(
    .WIDTH($bits(p2d_pkg::res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .pop_i  (pop_i),
    .rdata_o(res_rdata),
    .empty_o(empty_o)
  );

  assign res_out     = p2d_pkg::res_t'(res_rdata);
  assign u_coord_o   = res_out.u_coord;
  assign v_coord_o   = res_out.v_coord;
  assign pdf_value_o = res_out.pdf_value;
  assign row_index_o = res_out.row_index;
  assign col_index_o = res_out.col_index;
  assign status_o    = res_out.status;

endmodule

// ===== hdl/p2d_chk.sv =====
module p2d_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         pop_i,
  input logic                         empty_o,
  input logic [p2d_pkg::FB-1:0]       u_coord_o,
  input logic [p2d_pkg::FB-1:0]       v_coord_o,
  input logic [p2d_pkg::PDF_W-1:0]    pdf_value_o,
  input logic [p2d_pkg::RB-1:0]       row_index_o,
  input logic [p2d_pkg::CB-1:0]       col_index_o,
  input logic                         status_o
);

  // zero-total status carries no point and no density
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && status_o) |-> (u_coord_o == '0 && v_coord_o == '0 && pdf_value_o == '0))
    else $error("status beat with nonzero payload");

  // a sampled coordinate lies inside its reported bin
  a_u_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && u_coord_o != '0) |->
      (u_coord_o[p2d_pkg::FB-1 -: p2d_pkg::CB] == col_index_o))
    else $error("u coordinate outside its column");

  a_v_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && v_coord_o != '0) |->
      (v_coord_o[p2d_pkg::FB-1 -: p2d_pkg::RB] == row_index_o))
    else $error("v coordinate outside its row");

  // a waiting beat holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(pdf_value_o) && $stable(u_coord_o)))
    else $error("result beat changed while stalled");

endmodule

bind piecewise_2d_inverse_cdf_sampler p2d_chk u_p2d_chk (.*);
